@@ rtl/qwds_pkg.sv @@
// ----------------------------------------------------------------------------
// qwds_pkg
// Shared constants and the quarter-wave sine table builder for the DDS source.
// ----------------------------------------------------------------------------
package qwds_pkg;

  localparam int unsigned IndexBitsDef  = 10;
  localparam int unsigned FracBitsDef   = 22;
  localparam int unsigned SampleBitsDef = 12;

  // byte address width of the register port: two 32-bit registers
  localparam int unsigned CfgAddrBits = 3;

  // register indexes, taken from paddr[2]
  localparam logic RegTuning = 1'b0;
  localparam logic RegMaxInc = 1'b1;

  localparam logic [63:0] TwoPiQ30 = 64'd6746518852;
  localparam logic [63:0] OneQ30   = 64'd1 << 30;

  // quarter table entry k: half + (half-1)*sin(2*pi*k/n), sine from a q30 taylor series
  function automatic logic [31:0] qw_entry(int unsigned k, int unsigned index_bits,
                                           int unsigned sample_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] half;
    logic [63:0] qlen;
    half = 64'd1 << (sample_bits - 1);
    qlen = 64'd1 << (index_bits - 2);
    if (k == 0) begin
      s = 64'd0;
    end else if (64'(k) >= qlen) begin
      s = OneQ30;
    end else begin
      x    = (64'(k) * TwoPiQ30) >> index_bits;
      x2   = (x * x) >> 30;
      term = x;
      pos  = x;
      neg  = 64'd0;
      for (int unsigned n = 3; n <= 15; n += 2) begin
        term = ((term * x2) >> 30) / 64'((n - 1) * n);
        if ((n & 3) == 3) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      s = (pos > neg) ? pos - neg : 64'd0;
      if (s > OneQ30) begin
        s = OneQ30;
      end
    end
    return 32'(half + (((half - 64'd1) * s) >> 30));
  endfunction

endpackage

@@ rtl/quarter_wave_dds_sine_top.sv @@
// ----------------------------------------------------------------------------
// quarter_wave_dds_sine_top
// DDS sine source: clamped phase accumulator and quarter-wave table lookup.
// ----------------------------------------------------------------------------
// throughput: one item per cycle; the add lands in the phase register at the accepting edge,
// then the rom read and the folded output register each take a stage
// the whole pipeline holds while a sample waits on out_ready_i
// reset: phase cleared, tuning_increment 0, max_increment all ones, pipeline empty
// the sine rom is constant and needs no clearing pass
module quarter_wave_dds_sine_top #(
  parameter int unsigned IndexBits  = qwds_pkg::IndexBitsDef,
  parameter int unsigned FracBits   = qwds_pkg::FracBitsDef,
  parameter int unsigned SampleBits = qwds_pkg::SampleBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [qwds_pkg::CfgAddrBits-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // input items
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             run_i,
  // result items
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [SampleBits-1:0]            sample_o
);
  import qwds_pkg::*;

  localparam int unsigned PhaseBits = IndexBits + FracBits;
  localparam int unsigned SumBits   = (PhaseBits > 32) ? PhaseBits : 32;

  logic [31:0]           tuning_q;
  logic [31:0]           max_inc_q;
  logic [PhaseBits-1:0]  phase_q;
  logic [PhaseBits-1:0]  phase_d;
  logic                  s1_valid_q;
  logic                  s2_valid_q;
  logic                  out_valid_q;
  logic [SampleBits-1:0] sample_q;

  logic                  wr_en;
  logic                  adv;
  logic                  in_acc;
  logic [31:0]           inc;
  logic [SumBits-1:0]    sum;
  logic [SampleBits-1:0] entry;
  logic                  negate;

  // register port
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == RegMaxInc) ? max_inc_q : tuning_q;

  // pipeline moves as one whenever the output slot is free or being emptied
  assign adv        = ~out_valid_q | out_ready_i;
  assign in_ready_o = adv;
  assign in_acc     = in_valid_i & in_ready_o;

  assign inc     = (tuning_q > max_inc_q) ? max_inc_q : tuning_q;
  assign sum     = SumBits'(phase_q) + SumBits'(inc);
  assign phase_d = run_i ? sum[PhaseBits-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tuning_q    <= '0;
      max_inc_q   <= '1;
      phase_q     <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        if (paddr[2] == RegTuning) begin
          tuning_q <= pwdata;
        end else begin
          max_inc_q <= pwdata;
        end
      end
      if (in_acc) begin
        phase_q <= phase_d;
      end
      if (adv) begin
        s1_valid_q  <= in_acc & run_i;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  qwds_lookup #(
    .IndexBits  (IndexBits),
    .SampleBits (SampleBits)
  ) u_lookup (
    .clk_i    (clk_i),
    .en_i     (adv),
    .index_i  (phase_q[PhaseBits-1 -: IndexBits]),
    .entry_o  (entry),
    .negate_o (negate)
  );

  // max minus entry is the bitwise complement
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sample_q <= negate ? ~entry : entry;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

  a_stop_clears_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !run_i |=> phase_q == '0)
    else $error("phase not cleared after a stop item");

  a_run_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && run_i |=> s1_valid_q)
    else $error("running item lost at the first stage");

  a_stall_holds_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(phase_q) && $stable(s1_valid_q) && $stable(s2_valid_q))
    else $error("pipeline moved during a stall");

  a_stage_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && adv |=> out_valid_q)
    else $error("looked-up item did not reach the output");

endmodule

@@ rtl/qwds_lookup.sv @@
// ----------------------------------------------------------------------------
// qwds_lookup
// Folds a table index onto the quarter-wave ROM and registers the entry read.
// ----------------------------------------------------------------------------
module qwds_lookup #(
  parameter int unsigned IndexBits  = qwds_pkg::IndexBitsDef,
  parameter int unsigned SampleBits = qwds_pkg::SampleBitsDef
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [IndexBits-1:0]  index_i,
  output logic [SampleBits-1:0] entry_o,
  output logic                  negate_o
);
  import qwds_pkg::*;

  localparam int unsigned AddrBits   = IndexBits - 1;
  localparam int unsigned QuarterLen = 1 << (IndexBits - 2);
  localparam int unsigned Depth      = QuarterLen + 1;

  logic [SampleBits-1:0] rom [Depth];

  for (genvar k = 0; k < Depth; k++) begin : g_rom
    assign rom[k] = SampleBits'(qw_entry(k, IndexBits, SampleBits));
  end

  logic [1:0]            quad;
  logic [IndexBits-3:0]  low;
  logic [AddrBits-1:0]   addr;
  logic                  negate;
  logic [SampleBits-1:0] entry_q;
  logic                  negate_q;

  assign quad = index_i[IndexBits-1 -: 2];
  assign low  = index_i[IndexBits-3:0];

  // odd quarters mirror the index
  assign addr = quad[0] ? (AddrBits'(QuarterLen) - {1'b0, low}) : {1'b0, low};
  // lower half of the wave, except the exact half-way point which reads entry zero as is
  assign negate = quad[1] & ~(~quad[0] & (low == '0));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_q  <= rom[addr];
      negate_q <= negate;
    end
  end

  assign entry_o  = entry_q;
  assign negate_o = negate_q;

endmodule
